>>> design/pua_pkg.sv
// ----------------------------------------------------------------------------
// pua_pkg: shared types and constants for the polar unwrap address generator
// Register codes, field widths, phase constants and the Q1.15 sine function
// that fills the column trig ROM at elaboration.
// ----------------------------------------------------------------------------
package pua_pkg;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 10;
    localparam int COORD_W = 10;
    localparam int EXT_W   = 11;
    localparam int RHO_W   = 11;
    localparam int TRIG_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

    localparam logic [COORD_W-1:0] RST_CENTER_X     = 10'd150;
    localparam logic [COORD_W-1:0] RST_CENTER_Y     = 10'd150;
    localparam logic [COORD_W-1:0] RST_RADIUS       = 10'd150;
    localparam logic [EXT_W-1:0]   RST_IMAGE_WIDTH  = 11'd300;
    localparam logic [EXT_W-1:0]   RST_IMAGE_HEIGHT = 11'd300;

    localparam logic [EXT_W-1:0] EXT_MAX = 11'd1024;

    // Phase is a 32-bit angle, 2^32 per full turn
    localparam logic [31:0] PHASE_OFFSET = 32'd1652856652;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam longint Q30        = 64'sd1073741824;
    localparam longint HALF_TURN  = 64'sd2147483648;
    localparam longint TWO_POW_32 = 64'sd4294967296;
    localparam longint A1 = 64'sd1686629713;
    localparam longint A3 = -64'sd693598668;
    localparam longint A5 = 64'sd85569306;
    localparam longint A7 = -64'sd5026995;
    localparam longint A9 = 64'sd172272;
    localparam longint Q15_HALF = 64'sd16384;
    localparam longint Q15_ONE  = 64'sd32768;
    localparam longint Q15_MAX  = 64'sd32767;

    // Sine of a 32-bit phase in Q1.15; used only to build constant tables
    function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [31:0] p);
        longint s;
        longint z2;
        longint acc;
        longint r;
        longint mag;
        s = longint'({32'b0, p});
        if (s >= HALF_TURN)
            s = s - TWO_POW_32;
        // fold into the quarter turn around zero
        if (s > Q30)
            s = HALF_TURN - s;
        else if (s < -Q30)
            s = -HALF_TURN - s;
        z2  = (s * s) / Q30;
        acc = A9;
        acc = A7 + (acc * z2) / Q30;
        acc = A5 + (acc * z2) / Q30;
        acc = A3 + (acc * z2) / Q30;
        acc = A1 + (acc * z2) / Q30;
        r   = (acc * s) / Q30;
        mag = (r < 0) ? -r : r;
        mag = (mag + Q15_HALF) / Q15_ONE;
        if (mag > Q15_MAX)
            mag = Q15_MAX;
        return (r < 0) ? TRIG_W'(-mag) : TRIG_W'(mag);
    endfunction

endpackage

>>> design/pua_trig_rom.sv
// ----------------------------------------------------------------------------
// pua_trig_rom: column-indexed sine and negated cosine ROM
// One entry per column address, built at elaboration from the phase step of
// the strip width; registered read.
// ----------------------------------------------------------------------------
module pua_trig_rom
    import pua_pkg::*;
#(
    parameter int STRIP_WIDTH = 942
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [COL_W-1:0]         addr,
    output logic signed [TRIG_W-1:0] sin_q15,
    output logic signed [TRIG_W-1:0] neg_cos_q15
);

    localparam int ROM_DEPTH = 2 ** COL_W;
    localparam longint PHASE_STEP = TWO_POW_32 / STRIP_WIDTH;
    localparam longint PHASE_REM  = TWO_POW_32 % STRIP_WIDTH;
    localparam longint SW_L       = longint'(STRIP_WIDTH);

    typedef logic [2*TRIG_W-1:0] rom_array_t [ROM_DEPTH];

    // Entry i holds the sine and negated cosine of the angle of column i:
    // floor((i+1) * 2^32 / STRIP_WIDTH) plus PHASE_OFFSET, stepped by quotient and remainder
    function automatic rom_array_t build_rom();
        rom_array_t tbl;
        longint q;
        longint r;
        logic [31:0] ph;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
        q = 0;
        r = 0;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            q = q + PHASE_STEP;
            r = r + PHASE_REM;
            if (r >= SW_L)
            begin
                r = r - SW_L;
                q = q + 1;
            end
            ph = q[31:0] + PHASE_OFFSET;
            sn = sine_q15(ph);
            cs = sine_q15(ph + QUARTER_TURN);
            tbl[i] = {sn, TRIG_W'(-cs)};
        end
        return tbl;
    endfunction

    localparam rom_array_t ROM = build_rom();

    logic [2*TRIG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= ROM[addr];
    end

    assign sin_q15     = data_reg[2*TRIG_W-1:TRIG_W];
    assign neg_cos_q15 = data_reg[TRIG_W-1:0];

endmodule

>>> design/pua_axis.sv
// ----------------------------------------------------------------------------
// pua_axis: one coordinate axis of the sample point
// Multiply-add of center and rho times trig, then floor, clamp and bounds
// flag, over two registered stages.
// ----------------------------------------------------------------------------
module pua_axis
    import pua_pkg::*;
(
    input  logic                     clk,
    input  logic                     en_mac,
    input  logic                     en_clamp,
    input  logic [COORD_W-1:0]       center,
    input  logic signed [RHO_W-1:0]  rho,
    input  logic signed [TRIG_W-1:0] trig,
    input  logic [EXT_W-1:0]         extent,
    output logic [COORD_W-1:0]       coord,
    output logic                     in_bounds
);

    localparam int PROD_W = RHO_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_W = TRIG_W - 1;
    localparam int INT_W  = ACC_W - FRAC_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [INT_W-1:0]  whole;
    logic [EXT_W-1:0]         ext;
    logic                     below;
    logic                     beyond;
    logic [COORD_W-1:0]       coord_next;
    logic [COORD_W-1:0]       coord_reg;
    logic                     inside_reg;

    assign prod     = rho * trig;
    assign acc_next = $signed({{(ACC_W-COORD_W-FRAC_W){1'b0}}, center, {FRAC_W{1'b0}}})
                    + {prod[PROD_W-1], prod};

    always_ff @(posedge clk)
    begin
        if (en_mac)
            acc_reg <= acc_next;
    end

    // Floor to whole pixels is the arithmetic drop of the fraction bits
    assign whole = acc_reg[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (extent == '0)
            ext = EXT_W'(1);
        else if (extent > EXT_MAX)
            ext = EXT_MAX;
        else
            ext = extent;
    end

    assign below  = whole[INT_W-1];
    assign beyond = !below && ({1'b0, whole[INT_W-2:0]} >= INT_W'(ext));

    always_comb
    begin
        if (below)
            coord_next = '0;
        else if (beyond)
            coord_next = COORD_W'(ext - EXT_W'(1));
        else
            coord_next = whole[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_clamp)
        begin
            coord_reg  <= coord_next;
            inside_reg <= !below && !beyond;
        end
    end

    assign coord     = coord_reg;
    assign in_bounds = inside_reg;

endmodule

>>> design/polar_unwrap_address_gen_top.sv
// ----------------------------------------------------------------------------
// polar_unwrap_address_gen_top: polar unwrap source address generator
// Maps one strip pixel (row, column) to the clamped source image coordinate.
// ----------------------------------------------------------------------------
// Takes one item per clock: busy stays low, so start may be held high every
// cycle. The result of an accepted item is on the result ports, marked by
// done, after these registered steps in order: the column trig ROM read,
// the rho-times-trig multiply-add, then floor and clamp. done lasts one
// cycle and the receiver must take it then. Write configuration only while
// no item is in flight.
// ----------------------------------------------------------------------------
module polar_unwrap_address_gen_top
    import pua_pkg::*;
#(
    parameter int STRIP_WIDTH = 942
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ROW_W-1:0]      strip_row,
    input  logic [COL_W-1:0]      strip_col,
    output logic                  done,
    output logic [COORD_W-1:0]    source_x,
    output logic [COORD_W-1:0]    source_y,
    output logic                  inside_image,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [COORD_W-1:0] radius_reg;
    logic [EXT_W-1:0]   image_width_reg;
    logic [EXT_W-1:0]   image_height_reg;

    logic                     accept;
    logic                     rom_vld_reg;
    logic                     mac_vld_reg;
    logic                     done_reg;
    logic signed [RHO_W-1:0]  rho_next;
    logic signed [RHO_W-1:0]  rho_reg;
    logic signed [TRIG_W-1:0] sin_q15;
    logic signed [TRIG_W-1:0] neg_cos_q15;
    logic                     inside_x;
    logic                     inside_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            radius_reg       <= RST_RADIUS;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:     center_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_W-1:0];
                CFG_RADIUS:       radius_reg       <= cfg_data[COORD_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // rho = radius - row - 1, negative past the center
    assign rho_next = $signed({1'b0, radius_reg})
                    - $signed({{(RHO_W-ROW_W){1'b0}}, strip_row})
                    - RHO_W'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
            rho_reg <= rho_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_vld_reg <= 1'b0;
            mac_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rom_vld_reg <= accept;
            mac_vld_reg <= rom_vld_reg;
            done_reg    <= mac_vld_reg;
        end
    end

    pua_trig_rom #(
        .STRIP_WIDTH (STRIP_WIDTH)
    ) u_rom (
        .clk         (clk),
        .en          (accept),
        .addr        (strip_col),
        .sin_q15     (sin_q15),
        .neg_cos_q15 (neg_cos_q15)
    );

    pua_axis u_axis_x (
        .clk       (clk),
        .en_mac    (rom_vld_reg),
        .en_clamp  (mac_vld_reg),
        .center    (center_x_reg),
        .rho       (rho_reg),
        .trig      (sin_q15),
        .extent    (image_width_reg),
        .coord     (source_x),
        .in_bounds (inside_x)
    );

    pua_axis u_axis_y (
        .clk       (clk),
        .en_mac    (rom_vld_reg),
        .en_clamp  (mac_vld_reg),
        .center    (center_y_reg),
        .rho       (rho_reg),
        .trig      (neg_cos_q15),
        .extent    (image_height_reg),
        .coord     (source_y),
        .in_bounds (inside_y)
    );

    assign done         = done_reg;
    assign inside_image = inside_x && inside_y;

endmodule

>>> design/pua_checker.sv
// ----------------------------------------------------------------------------
// pua_checker: port-level checks for the polar unwrap address generator
// Watches start, busy and done; bound to the top level below.
// ----------------------------------------------------------------------------
module pua_checker
    import pua_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [ROW_W-1:0]      strip_row,
    input  logic [COL_W-1:0]      strip_col,
    input  logic                  done,
    input  logic [COORD_W-1:0]    source_x,
    input  logic [COORD_W-1:0]    source_y,
    input  logic                  inside_image,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // never hold off an item
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every accepted item gives its result, marked by done
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after accept");

    // no result without an accepted item before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##3 !done)
        else $error("result without accepted item");

    // a flagged result never shows up while input is held off
    a_inside_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && inside_image) |-> !busy)
        else $error("inside flag while busy");

endmodule

bind polar_unwrap_address_gen_top pua_checker u_pua_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: polar unwrap address generator
// Drives strip pixels through the command port under several register
// settings and sender idle patterns. Each result is checked field by field
// against a local fixed-point model of the polar-to-image mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pua_pkg::*;

    localparam int STRIP_WIDTH   = 942;
    localparam int STRIP_HEIGHT  = 100;
    localparam int LATENCY       = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 40;

    // spare register indexes, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // 150 degrees minus 0.2 rad, in 2^32 per turn
    localparam logic [31:0] ANGLE_BIAS   = 32'd1652856652;
    localparam logic [31:0] ANGLE_90DEG  = 32'h4000_0000;
    localparam longint      ONE_Q30      = 64'sd1073741824;
    localparam longint      ANGLE_HALF   = 64'sd2147483648;
    localparam longint      ANGLE_FULL   = 64'sd4294967296;
    // odd sine polynomial, highest order first
    localparam longint SINE_COEF [5] = '{64'sd172272, -64'sd5026995, 64'sd85569306,
                                         -64'sd693598668, 64'sd1686629713};

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } strip_pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               in_image;
    } source_coord_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ROW_W-1:0]      strip_row;
    logic [COL_W-1:0]      strip_col;
    logic                  done;
    logic [COORD_W-1:0]    source_x;
    logic [COORD_W-1:0]    source_y;
    logic                  inside_image;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    strip_pixel_t  pixel_queue[$];
    source_coord_t expected_coords[$];

    int items_accepted = 0;
    int items_retired  = 0;
    int send_idle_pct  = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // register copies seen by the predictor
    logic [COORD_W-1:0] sh_center_x     = RST_CENTER_X;
    logic [COORD_W-1:0] sh_center_y     = RST_CENTER_Y;
    logic [COORD_W-1:0] sh_radius       = RST_RADIUS;
    logic [EXT_W-1:0]   sh_image_width  = RST_IMAGE_WIDTH;
    logic [EXT_W-1:0]   sh_image_height = RST_IMAGE_HEIGHT;

    polar_unwrap_address_gen_top #(
        .STRIP_WIDTH (STRIP_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .strip_row    (strip_row),
        .strip_col    (strip_col),
        .done         (done),
        .source_x     (source_x),
        .source_y     (source_y),
        .inside_image (inside_image),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Q1.15 sine of a 32-bit angle
    function automatic logic signed [TRIG_W-1:0] trig_q15(input logic [31:0] angle);
        longint a;
        longint a_sq;
        longint poly;
        longint prod;
        longint mag;
        a = longint'({32'd0, angle});
        if (a >= ANGLE_HALF)
            a = a - ANGLE_FULL;
        // fold onto the quarter turn around zero
        if (a > ONE_Q30)
            a = ANGLE_HALF - a;
        else if (a < -ONE_Q30)
            a = -ANGLE_HALF - a;
        a_sq = (a * a) / ONE_Q30;
        poly = SINE_COEF[0];
        for (int k = 1; k < 5; k++)
            poly = SINE_COEF[k] + (poly * a_sq) / ONE_Q30;
        prod = (poly * a) / ONE_Q30;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 16384) / 32768;
        if (mag > 32767)
            mag = 32767;
        return (prod < 0) ? TRIG_W'(-mag) : TRIG_W'(mag);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_axis(input longint v,
                                                      input logic [EXT_W-1:0] extent,
                                                      output bit in_range);
        longint e;
        logic [COORD_W-1:0] c;
        e = longint'(extent);
        if (e < 1)
            e = 1;
        if (e > 1024)
            e = 1024;
        in_range = 1'b1;
        if (v < 0)
        begin
            in_range = 1'b0;
            c = '0;
        end
        else if (v >= e)
        begin
            in_range = 1'b0;
            c = COORD_W'(e - 1);
        end
        else
        begin
            c = COORD_W'(v);
        end
        return c;
    endfunction

    function automatic source_coord_t map_strip_pixel(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        longint rho;
        longint step;
        logic [31:0] phase;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
        longint x;
        longint y;
        bit in_x;
        bit in_y;
        source_coord_t r;
        rho   = longint'(sh_radius) - longint'(row) - 1;
        step  = ((longint'(col) + 1) <<< 32) / STRIP_WIDTH;
        phase = step[31:0] + ANGLE_BIAS;
        sn    = trig_q15(phase);
        cs    = trig_q15(phase + ANGLE_90DEG);
        // arithmetic shift gives an exact floor
        x = ((longint'(sh_center_x) <<< 15) + rho * longint'(sn)) >>> 15;
        y = ((longint'(sh_center_y) <<< 15) - rho * longint'(cs)) >>> 15;
        r.x        = clamp_axis(x, sh_image_width, in_x);
        r.y        = clamp_axis(y, sh_image_height, in_y);
        r.in_image = in_x && in_y;
        return r;
    endfunction

    task automatic report_field(input string name, input int exp_v, input int act_v);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    endtask

    // Driver: hold start until the item is taken, then advance
    always @(negedge clk)
    begin
        bit took;
        took = (items_accepted != items_retired);
        if (took)
        begin
            void'(pixel_queue.pop_front());
            items_retired++;
        end
        if (start && !took)
        begin
            start <= 1'b1;
        end
        else if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            start     <= 1'b1;
            strip_row <= pixel_queue[0].row;
            strip_col <= pixel_queue[0].col;
        end
        else
        begin
            start     <= 1'b0;
            strip_row <= ROW_W'($urandom);
            strip_col <= COL_W'($urandom);
        end
    end

    // Monitor: check results, record accepted items and register writes
    always @(posedge clk)
    begin
        source_coord_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_coords.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual x=%0d y=%0d in=%0d",
                                 $time, source_x, source_y, inside_image);
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (source_x !== want.x)
                        report_field("source_x", want.x, source_x);
                    if (source_y !== want.y)
                        report_field("source_y", want.y, source_y);
                    if (inside_image !== want.in_image)
                        report_field("inside_image", want.in_image, inside_image);
                end
            end
            if (start && !busy)
            begin
                expected_coords.push_back(map_strip_pixel(strip_row, strip_col));
                items_accepted++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_X:     sh_center_x     = cfg_data[COORD_W-1:0];
                    CFG_CENTER_Y:     sh_center_y     = cfg_data[COORD_W-1:0];
                    CFG_RADIUS:       sh_radius       = cfg_data[COORD_W-1:0];
                    CFG_IMAGE_WIDTH:  sh_image_width  = cfg_data;
                    CFG_IMAGE_HEIGHT: sh_image_height = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || start || expected_coords.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_data  <= CFG_DATA_W'($urandom);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                                 input logic [CFG_DATA_W-1:0] rad,
                                 input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic run_random_pixels(input int count, input int idle_pct);
        strip_pixel_t p;
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            // bias toward the strip area, keep some full-range noise
            p.row = ($urandom_range(3) != 0) ? ROW_W'($urandom_range(STRIP_HEIGHT - 1))
                                             : ROW_W'($urandom);
            p.col = ($urandom_range(6) != 0) ? COL_W'($urandom_range(STRIP_WIDTH - 1))
                                             : COL_W'($urandom);
            pixel_queue.push_back(p);
        end
        wait_drained();
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_extent();
        if ($urandom_range(3) == 0)
            return CFG_DATA_W'($urandom_range(2047));
        return CFG_DATA_W'($urandom_range(1, 1024));
    endfunction

    initial
    begin
        int idle_plan [3];
        idle_plan = '{0, 80, 25};
        rst_n     = 1'b0;
        start     = 1'b0;
        strip_row = '0;
        strip_col = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pixels under the reset setting
        send_idle_pct = 0;
        pixel_queue.push_back('{8'd0,   10'd0});
        pixel_queue.push_back('{8'd0,   10'd1023});
        pixel_queue.push_back('{8'd255, 10'd0});
        pixel_queue.push_back('{8'd255, 10'd1023});
        pixel_queue.push_back('{8'd0,   10'd940});
        pixel_queue.push_back('{8'd0,   10'd941});
        pixel_queue.push_back('{8'd0,   10'd942});
        pixel_queue.push_back('{8'd0,   10'd235});
        pixel_queue.push_back('{8'd0,   10'd470});
        pixel_queue.push_back('{8'd0,   10'd706});
        pixel_queue.push_back('{8'd149, 10'd300});
        pixel_queue.push_back('{8'd150, 10'd300});
        pixel_queue.push_back('{8'd99,  10'd600});
        pixel_queue.push_back('{8'd100, 10'd600});
        pixel_queue.push_back('{8'd200, 10'd150});
        pixel_queue.push_back('{8'd128, 10'd512});
        wait_drained();
        run_random_pixels(100, 25);

        for (int k = 0; k < 12; k++)
        begin
            case (k)
                0: apply_setting(11'd0, 11'd0, 11'd1023, 11'd1024, 11'd1024);
                1: apply_setting(11'd1023, 11'd1023, 11'd1, 11'd0, 11'd2047);
                2:
                begin
                    apply_setting(11'd512, 11'd512, 11'd0, 11'd1, 11'd1);
                    // drop writes to unused indexes
                    write_reg(CFG_SPARE_LO, 11'h7FF);
                    write_reg(CFG_SPARE_HI, 11'h000);
                end
                3: apply_setting(11'h7FF, 11'd0, 11'd1023, 11'd2047, 11'd0);
                default:
                begin
                    apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom_range(1023)),
                                  random_extent(), random_extent());
                    if ($urandom_range(2) == 0)
                        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
                end
            endcase
            run_random_pixels(150, idle_plan[k % 3]);
        end

        wait_drained();
        if (error_count == 0 && expected_coords.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
